// ----- rtl/sawmd_pkg.sv -----
package sawmd_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int AXIS_W       = 16;
  localparam int TIME_FIELD_W = 32;
  localparam int MAG_FIELD_W  = 16;
  localparam int IN_TDATA_W   = 3 * AXIS_W + TIME_FIELD_W;
  localparam int OUT_TDATA_W  = 24;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 16;

  // Baseline is unsigned Q16.16.
  localparam int BASE_W = 32;
  localparam int FRAC_W = 16;

  // Shared multiplier: 33-bit signed by 17-bit signed.
  localparam int MA_W   = BASE_W + 1;
  localparam int MB_W   = 17;
  localparam int PROD_W = MA_W + MB_W;

  // Iteration counter covers the 32 quotient bits of the running mean.
  localparam int ITER_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_LIMIT     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_HOLDOFF   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_SAMPLES  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EMA_ALPHA_Q16   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_JERK_THRESHOLD  = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_JERK_SPAN       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_WAKE_HOLDOFF    = 4'd7;

  // Register values after reset.
  localparam logic [15:0] RST_SHAKE_THRESHOLD = 16'd15000;
  localparam logic [15:0] RST_SPIKE_LIMIT     = 16'd4000;
  localparam logic [15:0] RST_SHAKE_HOLDOFF   = 16'd1500;
  localparam logic [7:0]  RST_SETTLE_SAMPLES  = 8'd30;
  localparam logic [15:0] RST_EMA_ALPHA_Q16   = 16'd328;
  localparam logic [15:0] RST_JERK_THRESHOLD  = 16'd12000;
  localparam logic [15:0] RST_JERK_SPAN       = 16'd800;
  localparam logic [15:0] RST_WAKE_HOLDOFF    = 16'd1500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_SPIKE,
    ST_MEAN_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMA_SUB,
    ST_EMA_MUL,
    ST_EMA_RND,
    ST_EMA_ADD,
    ST_DEV,
    ST_SHAKE,
    ST_WINDOW,
    ST_WAKE,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/shake_and_wake_motion_detector_top.sv -----
// Each sample passes through the SAMPLE_BITS-step square root and then the 32-step
// running-mean divider while the baseline is settling, the EMA update once it follows it,
// or neither when the sample is a spike. A new input beat is taken only after the result
// of the previous one has been loaded into the result register.
// Reset (rst, synchronous, active high) restores the register defaults and clears the
// sequencer, the state kept between samples and the result register.
module shake_and_wake_motion_detector_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata, lowest bit first: accel_x[15:0], accel_y[15:0], accel_z[15:0], time_ms[31:0].
  input  logic [sawmd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata, lowest bit first: shake flag, wake flag, magnitude[15:0], six zero bits.
  output logic [sawmd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sawmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sawmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import sawmd_pkg::*;

  // The magnitude of a SAMPLE_BITS vector fits in SAMPLE_BITS bits; the sum of the
  // three squares fits in twice that.
  localparam int MAG_W = SAMPLE_BITS;
  localparam int SUM_W = 2 * SAMPLE_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are only expected while the block is idle,
  // so the channel is always ready.
  // ---------------------------------------------------------------------------
  logic [15:0] shake_threshold;
  logic [15:0] spike_limit;
  logic [15:0] shake_holdoff;
  logic [7:0]  settle_samples;
  logic [15:0] ema_alpha_q16;
  logic [15:0] jerk_threshold;
  logic [15:0] jerk_span;
  logic [15:0] wake_holdoff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shake_threshold <= RST_SHAKE_THRESHOLD;
      spike_limit     <= RST_SPIKE_LIMIT;
      shake_holdoff   <= RST_SHAKE_HOLDOFF;
      settle_samples  <= RST_SETTLE_SAMPLES;
      ema_alpha_q16   <= RST_EMA_ALPHA_Q16;
      jerk_threshold  <= RST_JERK_THRESHOLD;
      jerk_span       <= RST_JERK_SPAN;
      wake_holdoff    <= RST_WAKE_HOLDOFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHAKE_THRESHOLD: shake_threshold <= cfg_data;
        REG_SPIKE_LIMIT:     spike_limit     <= cfg_data;
        REG_SHAKE_HOLDOFF:   shake_holdoff   <= cfg_data;
        REG_SETTLE_SAMPLES:  settle_samples  <= cfg_data[7:0];
        REG_EMA_ALPHA_Q16:   ema_alpha_q16   <= cfg_data;
        REG_JERK_THRESHOLD:  jerk_threshold  <= cfg_data;
        REG_JERK_SPAN:       jerk_span       <= cfg_data;
        REG_WAKE_HOLDOFF:    wake_holdoff    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and the working registers of the current sample.
  // ---------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic [ITER_W-1:0]             iter;
  logic signed [SAMPLE_BITS-1:0] ax;
  logic signed [SAMPLE_BITS-1:0] ay;
  logic signed [SAMPLE_BITS-1:0] az;
  logic [TIME_BITS-1:0]          now;
  logic signed [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]              sum;
  logic [MAG_W-1:0]              sq_rem;
  logic [MAG_W-1:0]              root;
  logic signed [MAG_W:0]         delta;
  logic [7:0]                    div_rem;
  logic [BASE_W-1:0]             quo;
  logic signed [MA_W-1:0]        ema_d;
  logic                          shaking;
  logic                          shake_ev;
  logic                          wake_ev;

  // State carried from sample to sample.
  logic [MAG_W-1:0]     previous_magnitude;
  logic                 primed;
  logic [7:0]           settle_count;
  logic [BASE_W-1:0]    baseline;
  logic                 shaking_before;
  logic [TIME_BITS-1:0] last_shake_time;
  logic [TIME_BITS-1:0] last_wake_time;
  logic [TIME_BITS-1:0] window_start;
  logic [MAG_W-1:0]     max_rise;
  logic [MAG_W-1:0]     max_fall;

  // ---------------------------------------------------------------------------
  // The shared multiplier. It forms the three squares, the baseline times the
  // settle count for the running mean, and alpha times the EMA difference.
  // ---------------------------------------------------------------------------
  logic signed [MA_W-1:0]   mult_a;
  logic signed [MB_W-1:0]   mult_b;
  logic signed [PROD_W-1:0] product;

  assign product = mult_a * mult_b;

  // ---------------------------------------------------------------------------
  // Datapath terms that steer the sequencer or feed several steps.
  // ---------------------------------------------------------------------------
  logic [15:0]         mag16;
  logic [BASE_W-1:0]   magq;
  logic [MAG_W+1:0]    sq_trial;
  logic [MAG_W+1:0]    sq_cand;
  logic                sq_take;
  logic signed [MAG_W:0] delta_now;
  logic [MAG_W-1:0]    delta_abs;
  logic                spike_now;
  logic                settling;
  logic [7:0]          div_by;
  logic [8:0]          div_part;
  logic                div_take;
  logic [39:0]         mean_num;
  logic signed [34:0]  ema_sum;
  logic [BASE_W-1:0]   ema_base;
  logic signed [MA_W-1:0] dev_diff;
  logic [BASE_W-1:0]   dev_abs;
  logic                win_expired;
  logic [MAG_W-1:0]    rise_base;
  logic [MAG_W-1:0]    fall_base;
  logic [MAG_W-1:0]    delta_pos;
  logic [MAG_W-1:0]    delta_neg;
  logic                wake_now;
  logic                out_free;

  assign mag16 = 16'(root);
  assign magq  = {mag16, 16'h0000};

  // Square root, one result bit per cycle: bring down two bits of the sum and
  // try to subtract 4 * root + 1. Until the last step the remainder stays below
  // twice a 15-bit root, so MAG_W bits hold it.
  assign sq_cand  = {sq_rem, sum[SUM_W-1 -: 2]};
  assign sq_trial = {root, 2'b01};
  assign sq_take  = (sq_cand >= sq_trial);

  // Spike guard on the change against the previous magnitude.
  assign delta_now = signed'({1'b0, root}) - signed'({1'b0, previous_magnitude});
  assign delta_abs = delta_now[MAG_W] ? MAG_W'(-delta_now) : delta_now[MAG_W-1:0];
  assign spike_now = primed && (16'(delta_abs) > spike_limit);
  assign settling  = (settle_count < settle_samples);

  // Running mean: restoring division by settle_count + 1, one quotient bit per
  // cycle. The count never exceeds 254 here, so the divisor fits in eight bits,
  // and the top eight numerator bits are already below it.
  assign div_by   = settle_count + 8'd1;
  assign div_part = {div_rem, quo[BASE_W-1]};
  assign div_take = (div_part >= {1'b0, div_by});
  assign mean_num = prod[39:0] + {8'h00, magq};

  // EMA update: the product is already rounded, so an arithmetic shift gives
  // the floor, and the result is clamped to the unsigned Q16.16 range.
  assign ema_sum = signed'({3'b000, baseline}) + 35'(signed'(prod[PROD_W-1:FRAC_W]));
  always_comb begin
    if (ema_sum[34]) begin
      ema_base = '0;
    end else if (ema_sum[33:32] != 2'b00) begin
      ema_base = '1;
    end else begin
      ema_base = ema_sum[31:0];
    end
  end

  // Deviation of the magnitude from the baseline (updated first unless the sample is a spike).
  assign dev_diff = signed'({1'b0, magq}) - signed'({1'b0, baseline});
  assign dev_abs  = dev_diff[MA_W-1] ? BASE_W'(-dev_diff) : dev_diff[BASE_W-1:0];

  // Jerk window: an expired window starts afresh before this delta is applied.
  assign win_expired = ((now - window_start) > TIME_BITS'(jerk_span));
  assign rise_base   = win_expired ? '0 : max_rise;
  assign fall_base   = win_expired ? '0 : max_fall;
  assign delta_pos   = delta[MAG_W-1:0];
  assign delta_neg   = MAG_W'(-delta);
  assign wake_now    = (16'(max_rise) > jerk_threshold) && (16'(max_fall) > jerk_threshold) &&
                       ((now - last_wake_time) > TIME_BITS'(wake_holdoff));

  // The result register can take a new beat when it is empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (iter == '0) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (iter == '0) state_next = ST_SPIKE;
      end
      ST_SPIKE: begin
        if (spike_now) begin
          state_next = ST_DEV;
        end else if (settling) begin
          state_next = ST_MEAN_MUL;
        end else begin
          state_next = ST_EMA_SUB;
        end
      end
      ST_MEAN_MUL: state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (iter == '0) state_next = ST_DEV;
      end
      ST_EMA_SUB:  state_next = ST_EMA_MUL;
      ST_EMA_MUL:  state_next = ST_EMA_RND;
      ST_EMA_RND:  state_next = ST_EMA_ADD;
      ST_EMA_ADD:  state_next = ST_DEV;
      ST_DEV:      state_next = ST_SHAKE;
      ST_SHAKE:    state_next = ST_WINDOW;
      ST_WINDOW: begin
        // The first sample only opens the window, so it skips the wake test.
        state_next = primed ? ST_WAKE : ST_FINISH;
      end
      ST_WAKE:     state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: the input handshake and the multiplier operands.
  // ---------------------------------------------------------------------------
  always_comb begin
    s_tready = 1'b0;
    mult_a   = '0;
    mult_b   = '0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SQUARE: begin
        // The counter runs from three down; x, y and z are squared in turn.
        case (iter)
          ITER_W'(3): begin
            mult_a = MA_W'(ax);
            mult_b = MB_W'(ax);
          end
          ITER_W'(2): begin
            mult_a = MA_W'(ay);
            mult_b = MB_W'(ay);
          end
          ITER_W'(1): begin
            mult_a = MA_W'(az);
            mult_b = MB_W'(az);
          end
          default: ;
        endcase
      end
      ST_MEAN_MUL: begin
        mult_a = signed'({1'b0, baseline});
        mult_b = signed'(MB_W'(settle_count));
      end
      ST_EMA_MUL: begin
        mult_a = ema_d;
        mult_b = signed'({1'b0, ema_alpha_q16});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers of the current sample. They need no reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ax   <= s_tdata[SAMPLE_BITS-1:0];
        ay   <= s_tdata[AXIS_W +: SAMPLE_BITS];
        az   <= s_tdata[2*AXIS_W +: SAMPLE_BITS];
        now  <= s_tdata[3*AXIS_W +: TIME_BITS];
        sum  <= '0;
        iter <= ITER_W'(3);
      end
      ST_SQUARE: begin
        // Each square is registered and added in the next cycle.
        prod <= product;
        if (iter != ITER_W'(3)) sum <= sum + prod[SUM_W-1:0];
        if (iter == '0) begin
          root   <= '0;
          sq_rem <= '0;
          iter   <= ITER_W'(MAG_W - 1);
        end else begin
          iter <= iter - 1'b1;
        end
      end
      ST_SQRT: begin
        sum  <= sum << 2;
        root <= {root[MAG_W-2:0], sq_take};
        if (sq_take) begin
          sq_rem <= MAG_W'(sq_cand - sq_trial);
        end else begin
          sq_rem <= sq_cand[MAG_W-1:0];
        end
        iter <= iter - 1'b1;
      end
      ST_SPIKE:    delta <= delta_now;
      ST_MEAN_MUL: prod <= product;
      ST_DIV_INIT: begin
        div_rem <= mean_num[39:32];
        quo     <= mean_num[31:0];
        iter    <= ITER_W'(BASE_W - 1);
      end
      ST_DIV: begin
        quo     <= {quo[BASE_W-2:0], div_take};
        div_rem <= div_take ? 8'(div_part - {1'b0, div_by}) : div_part[7:0];
        iter    <= iter - 1'b1;
      end
      ST_EMA_SUB: ema_d <= dev_diff;
      ST_EMA_MUL: prod  <= product;
      ST_EMA_RND: prod  <= prod + PROD_W'(32768);
      ST_DEV:     shaking <= (dev_abs > {shake_threshold, 16'h0000});
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State kept between samples and the event flags.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_magnitude <= '0;
      primed             <= 1'b0;
      settle_count       <= '0;
      baseline           <= '0;
      shaking_before     <= 1'b0;
      last_shake_time    <= '0;
      last_wake_time     <= '0;
      window_start       <= '0;
      max_rise           <= '0;
      max_fall           <= '0;
      shake_ev           <= 1'b0;
      wake_ev            <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            shake_ev <= 1'b0;
            wake_ev  <= 1'b0;
          end
        end
        ST_DIV: begin
          if (iter == '0) begin
            baseline     <= {quo[BASE_W-2:0], div_take};
            settle_count <= settle_count + 8'd1;
          end
        end
        ST_EMA_ADD: baseline <= ema_base;
        ST_SHAKE: begin
          // Shake fires only on the rising edge of the deviation test and after the shake holdoff.
          if (shaking && !shaking_before &&
              ((now - last_shake_time) > TIME_BITS'(shake_holdoff))) begin
            shake_ev        <= 1'b1;
            last_shake_time <= now;
          end
          shaking_before <= shaking;
        end
        ST_WINDOW: begin
          if (!primed) begin
            primed       <= 1'b1;
            window_start <= now;
            max_rise     <= '0;
            max_fall     <= '0;
          end else begin
            if (win_expired) window_start <= now;
            max_rise <= (!delta[MAG_W] && (delta_pos > rise_base)) ? delta_pos : rise_base;
            max_fall <= (delta[MAG_W] && (delta_neg > fall_base)) ? delta_neg : fall_base;
          end
        end
        ST_WAKE: begin
          if (wake_now) begin
            wake_ev        <= 1'b1;
            last_wake_time <= now;
            window_start   <= now;
            max_rise       <= '0;
            max_fall       <= '0;
          end
        end
        ST_FINISH: begin
          if (out_free) previous_magnitude <= root;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It is loaded as a sample finishes and empties when its
  // beat is taken; a load and a drain in the same cycle keep it full.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {6'b000000, mag16, wake_ev, shake_ev};
    end
  end

endmodule

// ----- rtl/sawmd_checker.sv -----
module sawmd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [sawmd_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import sawmd_pkg::*;

  // A sample is worked on through the sequencer states, so no beat follows straight after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again in the cycle after a beat");

  // A stalled result holds its beat.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A new result only appears when the sequencer has been busy with a sample.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while the block was idle");

endmodule

bind shake_and_wake_motion_detector_top sawmd_checker u_sawmd_checker (.*);
